// ===== src/nsc_pkg.sv =====
package nsc_pkg;

  localparam int LINE_CAPACITY = 256;
  localparam int LINE_CNT_W    = $clog2(LINE_CAPACITY);
  localparam int HEADER_LEN    = 7;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2a;
  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_LF     = 8'h0a;
  localparam logic [7:0] CHAR_NUL    = 8'h00;

  localparam logic [31:0] TAG_GGA  = 32'h4747_412c;
  localparam logic [31:0] TAG_VTG  = 32'h5654_472c;
  localparam logic [55:0] TAG_NTR  = 56'h2447_504e_5452_2c;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_GGA   = 2'd1,
    KIND_VTG   = 2'd2,
    KIND_GPNTR = 2'd3
  } kind_t;

endpackage

// ===== src/nsc_if.sv =====
interface nsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] sentence_kind;
  logic       checksum_ok;
  logic [7:0] computed_xor;
  logic [7:0] line_length;

  modport source (output valid, output sentence_kind, output checksum_ok,
                  output computed_xor, output line_length, input ready);
  modport sink (input valid, input sentence_kind, input checksum_ok,
                input computed_xor, input line_length, output ready);
endinterface

// ===== src/nmea_sentence_checker_core.sv =====
// channel   | port    | direction | payload
// ----------+---------+-----------+----------------------------------------------
// bytes     | in_if   | sink      | rx_byte
// results   | out_if  | source    | sentence_kind, checksum_ok, computed_xor,
//           |         |           | line_length
//
// one byte is taken every cycle while in_if.ready is high; the line state updates in the accepting cycle
// a line feed loads the result register, visible the cycle after acceptance
// a byte is accepted while the result register is empty or being drained
// rst_n is synchronous, active low, and clears the line state and out valid
module nmea_sentence_checker_core (
  input  logic          clk,
  input  logic          rst_n,
  nsc_byte_if.sink      in_if,
  nsc_result_if.source  out_if
);

  localparam int CW = nsc_pkg::LINE_CNT_W;

  logic [CW-1:0] line_count_r, line_count_nxt;
  logic [7:0]    logical_len_r, logical_len_nxt;
  logic [7:0]    running_xor_r, running_xor_nxt;
  logic [7:0]    xor_before_star_r, xor_before_star_nxt;
  logic          star_seen_r, star_seen_nxt;
  logic [1:0]    chars_after_star_r, chars_after_star_nxt;
  logic [7:0]    hex_digit_r [2];
  logic [7:0]    hex_digit_nxt [2];
  logic [7:0]    header_r [nsc_pkg::HEADER_LEN];
  logic [7:0]    header_nxt [nsc_pkg::HEADER_LEN];
  logic          zero_seen_r, zero_seen_nxt;

  logic          out_valid_r;
  logic [1:0]    kind_r;
  logic          ok_r;
  logic [7:0]    cx_r;
  logic [7:0]    len_r;

  logic          accept;
  logic          is_cr;
  logic          is_lf;
  logic          overflow;
  logic [7:0]    c;
  logic [7:0]    cx;
  logic          ok;
  nsc_pkg::kind_t kind;
  logic [4:0]    hi_val;
  logic [4:0]    lo_val;
  logic [31:0]   tag4;
  logic [55:0]   tag7;

  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] v;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      v = 5'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      v = 5'(ch - 8'h41 + 8'd10);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      v = 5'(ch - 8'h61 + 8'd10);
    end else begin
      v = 5'd16;
    end
    return v;
  endfunction

  assign c        = in_if.rx_byte;
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept   = in_if.valid && in_if.ready;
  assign is_cr    = (c == nsc_pkg::CHAR_CR);
  assign is_lf    = (c == nsc_pkg::CHAR_LF);
  assign overflow = (line_count_r >= CW'(nsc_pkg::LINE_CAPACITY - 1));

  // line state update
  always_comb begin
    line_count_nxt       = line_count_r;
    logical_len_nxt      = logical_len_r;
    running_xor_nxt      = running_xor_r;
    xor_before_star_nxt  = xor_before_star_r;
    star_seen_nxt        = star_seen_r;
    chars_after_star_nxt = chars_after_star_r;
    hex_digit_nxt        = hex_digit_r;
    header_nxt           = header_r;
    zero_seen_nxt        = zero_seen_r;
    if (accept && !is_cr) begin
      if (is_lf || overflow) begin
        line_count_nxt       = '0;
        logical_len_nxt      = '0;
        running_xor_nxt      = '0;
        xor_before_star_nxt  = '0;
        star_seen_nxt        = 1'b0;
        chars_after_star_nxt = '0;
        hex_digit_nxt        = '{default: '0};
        header_nxt           = '{default: '0};
        zero_seen_nxt        = 1'b0;
      end else begin
        line_count_nxt = line_count_r + CW'(1);
        if (!zero_seen_r) begin
          if (c == nsc_pkg::CHAR_NUL) begin
            zero_seen_nxt = 1'b1;
          end else begin
            if (logical_len_r < 8'(nsc_pkg::HEADER_LEN)) begin
              header_nxt[logical_len_r[2:0]] = c;
            end
            if (c == nsc_pkg::CHAR_STAR) begin
              xor_before_star_nxt  = (logical_len_r != 8'd0) ? running_xor_r : 8'd0;
              star_seen_nxt        = 1'b1;
              chars_after_star_nxt = '0;
              hex_digit_nxt        = '{default: '0};
            end else if (star_seen_r && chars_after_star_r < 2'd2) begin
              hex_digit_nxt[chars_after_star_r[0]] = c;
              chars_after_star_nxt = chars_after_star_r + 2'd1;
            end
            if (logical_len_r != 8'd0) begin
              running_xor_nxt = running_xor_r ^ c;
            end
            logical_len_nxt = logical_len_r + 8'd1;
          end
        end
      end
    end
  end

  // result of the line being closed
  always_comb begin
    cx     = star_seen_r ? xor_before_star_r : 8'd0;
    hi_val = hex_value(hex_digit_r[0]);
    lo_val = hex_value(hex_digit_r[1]);
    ok     = (header_r[0] == nsc_pkg::CHAR_DOLLAR) && (logical_len_r != 8'd0) &&
             star_seen_r && (chars_after_star_r >= 2'd2) &&
             !hi_val[4] && !lo_val[4] && ({hi_val[3:0], lo_val[3:0]} == cx);
    tag4   = {header_r[3], header_r[4], header_r[5], header_r[6]};
    tag7   = {header_r[0], header_r[1], header_r[2], tag4};
    priority if (header_r[0] == nsc_pkg::CHAR_DOLLAR && tag4 == nsc_pkg::TAG_GGA) begin
      kind = nsc_pkg::KIND_GGA;
    end else if (header_r[0] == nsc_pkg::CHAR_DOLLAR && tag4 == nsc_pkg::TAG_VTG) begin
      kind = nsc_pkg::KIND_VTG;
    end else if (tag7 == nsc_pkg::TAG_NTR) begin
      kind = nsc_pkg::KIND_GPNTR;
    end else begin
      kind = nsc_pkg::KIND_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r       <= '0;
      logical_len_r      <= '0;
      running_xor_r      <= '0;
      xor_before_star_r  <= '0;
      star_seen_r        <= 1'b0;
      chars_after_star_r <= '0;
      hex_digit_r        <= '{default: '0};
      header_r           <= '{default: '0};
      zero_seen_r        <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      line_count_r       <= line_count_nxt;
      logical_len_r      <= logical_len_nxt;
      running_xor_r      <= running_xor_nxt;
      xor_before_star_r  <= xor_before_star_nxt;
      star_seen_r        <= star_seen_nxt;
      chars_after_star_r <= chars_after_star_nxt;
      hex_digit_r        <= hex_digit_nxt;
      header_r           <= header_nxt;
      zero_seen_r        <= zero_seen_nxt;
      if (accept && is_lf) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && is_lf) begin
      kind_r <= kind;
      ok_r   <= ok;
      cx_r   <= cx;
      len_r  <= logical_len_r;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.sentence_kind = kind_r;
  assign out_if.checksum_ok   = ok_r;
  assign out_if.computed_xor  = cx_r;
  assign out_if.line_length   = len_r;

endmodule
